[rtl/lge_pkg.sv]
// lge_pkg: shared constants for the life generation engine
// grid size default, emitted-field limits and operation codes; no dependencies
`default_nettype none

package lge_pkg;

  localparam int GRID_DEFAULT = 16;
  localparam int FIELD_ROWS   = 16;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_EMIT  = 2'd2;

endpackage

`default_nettype wire

[rtl/lge_ram.sv]
// lge_ram: generic simple dual-port ram, one write and one read port
// read data registered; no dependencies
`default_nettype none

module lge_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/life_generation_engine_top.sv]
// life_generation_engine_top: b3/s23 life on a bounded grid, board held in a ram
// depends on lge_pkg (constants, mode codes) and lge_ram (board storage)
//
//   channel   handshake             fields
//   ------    ---------             ------
//   command   start / busy          mode, row_index, row_cells
//   result    strobe (one cycle)    out_row, out_cells, generation, last_row
//
// a row write goes straight to the ram and leaves busy low
// in a step, one ram read per row feeds a three-row window,
// and one shared row-rule unit computes and writes back one row per cycle
// an emit-only command reads min(GRID,16) rows, one ram read per row
// reset clears the board through per-row valid bits, no clearing pass
// results cannot be stalled; each is flagged by strobe for exactly one cycle
`default_nettype none

module life_generation_engine_top
  import lge_pkg::*;
#(
  parameter int GRID = GRID_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [3:0]  row_index,
  input  wire logic [15:0] row_cells,
  output logic             strobe,
  output logic [3:0]       out_row,
  output logic [15:0]      out_cells,
  output logic [15:0]      generation,
  output logic             last_row
);

  localparam int ADDR_W    = $clog2(GRID);
  localparam int CNT_W     = $clog2(GRID + 2);
  localparam int EMIT_ROWS = (GRID < FIELD_ROWS) ? GRID : FIELD_ROWS;

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_EMIT} state_t;

  state_t            state;
  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  ld;
  logic              rd_pend;
  logic [ADDR_W-1:0] rd_row;
  logic [GRID-1:0]   above;
  logic [GRID-1:0]   here;
  logic [GRID-1:0]   below;
  logic              win_valid;
  logic [ADDR_W-1:0] ctr;
  logic [GRID-1:0]   valid;
  logic [15:0]       gen_count;

  logic              accept;
  logic              rd_issue;
  logic              shift;
  logic [GRID-1:0]   rd_data_m;
  logic [GRID-1:0]   shift_in;
  logic [GRID-1:0]   new_row;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [GRID-1:0]   ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [GRID-1:0]   ram_rdata;

  // row rule unit: all columns of one row in parallel, edges read as dead
  function automatic logic [GRID-1:0] life_row(input logic [GRID-1:0] a,
                                               input logic [GRID-1:0] h,
                                               input logic [GRID-1:0] b);
    logic [GRID-1:0] a_l, a_r, h_l, h_r, b_l, b_r;
    logic [GRID-1:0] res;
    logic [3:0]      n;
    a_l = a << 1;
    a_r = a >> 1;
    h_l = h << 1;
    h_r = h >> 1;
    b_l = b << 1;
    b_r = b >> 1;
    for (int c = 0; c < GRID; c++) begin
      n = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c]) + 4'(h_l[c]) + 4'(h_r[c])
        + 4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
      res[c] = (n == 4'd3) || (h[c] && (n == 4'd2));
    end
    return res;
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    rd_issue  = ((state == ST_STEP) && (rd_cnt < CNT_W'(GRID)))
             || ((state == ST_EMIT) && (rd_cnt < CNT_W'(EMIT_ROWS)));
    ram_raddr = rd_cnt[ADDR_W-1:0];
    // rows never written since reset read as dead
    rd_data_m = valid[rd_row] ? ram_rdata : '0;
    shift     = (state == ST_STEP) && (rd_pend || (ld == CNT_W'(GRID)));
    shift_in  = rd_pend ? rd_data_m : '0;
    new_row   = life_row(above, here, below);
    ram_we    = 1'b0;
    ram_waddr = ctr;
    ram_wdata = new_row;
    if (state == ST_IDLE) begin
      if (accept && (mode == MODE_WRITE) && (row_index < GRID)) begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(row_index);
        ram_wdata = GRID'(row_cells);
      end
    end else if ((state == ST_STEP) && win_valid) begin
      // old row ctr is still in the window, so write back in place
      ram_we = 1'b1;
    end
  end

  lge_ram #(
    .WIDTH (GRID),
    .DEPTH (GRID)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      ld         <= '0;
      ctr        <= '0;
      rd_pend    <= 1'b0;
      win_valid  <= 1'b0;
      valid      <= '0;
      gen_count  <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe  <= 1'b0;
      rd_pend <= rd_issue;
      if (rd_issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
        rd_row <= ram_raddr;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_STEP: begin
                state     <= ST_STEP;
                gen_count <= gen_count + 16'd1;
                rd_cnt    <= '0;
                ld        <= '0;
                ctr       <= '0;
                above     <= '0;
                here      <= '0;
                below     <= '0;
                win_valid <= 1'b0;
              end
              MODE_EMIT: begin
                state  <= ST_EMIT;
                rd_cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_STEP: begin
          // window shifts one row per read, then once more with the dead edge
          if (shift) begin
            above <= here;
            here  <= below;
            below <= shift_in;
            ld    <= ld + CNT_W'(1);
          end
          win_valid <= shift && (ld >= CNT_W'(1));
          if (win_valid) begin
            ctr <= ctr + ADDR_W'(1);
            if (ctr < EMIT_ROWS) begin
              strobe     <= 1'b1;
              out_row    <= 4'(ctr);
              out_cells  <= 16'(new_row);
              generation <= gen_count;
              last_row   <= (ctr == ADDR_W'(EMIT_ROWS - 1));
            end
            if (ctr == ADDR_W'(GRID - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (rd_pend) begin
            strobe     <= 1'b1;
            out_row    <= 4'(rd_row);
            out_cells  <= 16'(rd_data_m);
            generation <= gen_count;
            last_row   <= (rd_row == ADDR_W'(EMIT_ROWS - 1));
            if (rd_row == ADDR_W'(EMIT_ROWS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state != ST_IDLE))
    else $error("result word without an operation in progress");

  a_last_row_index: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_row) |-> (out_row == 4'(EMIT_ROWS - 1)))
    else $error("last row flag on the wrong row");

  a_window_aligned: assert property (@(posedge clk) disable iff (rst)
    win_valid |-> (int'(ld) == int'(ctr) + 2))
    else $error("row window out of step with the write-back row");

  a_gen_increment: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_STEP)) |=> (gen_count == $past(gen_count) + 16'd1))
    else $error("generation count not advanced by a step");
`endif

endmodule

`default_nettype wire

[tb/tb_life_generation_engine_top.sv]
// tb_life_generation_engine_top: self-checking bench for the b3/s23 life engine
// depends on lge_pkg (mode codes) and life_generation_engine_top; predicts every emitted row
`default_nettype none

module tb_life_generation_engine_top
  import lge_pkg::*;
;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  row_index;
    logic [15:0] row_cells;
    int          idle_pct;
  } command_t;

  typedef struct {
    logic [3:0]  row;
    logic [15:0] cells;
    logic [15:0] gen;
    logic        last;
  } row_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = MODE_WRITE;
  logic [3:0]  row_index = '0;
  logic [15:0] row_cells = '0;
  logic        busy;
  logic        strobe;
  logic [3:0]  out_row;
  logic [15:0] out_cells;
  logic [15:0] generation;
  logic        last_row;

  command_t    cmd_q[$];
  row_word_t   rows_due[$];
  logic        word_taken = 1'b0;
  int          fail_cnt = 0;

  // predicted board and generation counter
  logic [15:0] life_board [16];
  logic [15:0] gen_count_q;

  life_generation_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .row_index  (row_index),
    .row_cells  (row_cells),
    .strobe     (strobe),
    .out_row    (out_row),
    .out_cells  (out_cells),
    .generation (generation),
    .last_row   (last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one row of the next generation; cells past the edge are dead
  function automatic logic [15:0] life_row(input logic [15:0] up, input logic [15:0] mid,
                                           input logic [15:0] down);
    logic [15:0] res;
    int          n;
    int          cc;
    res = '0;
    for (int c = 0; c < 16; c++) begin
      n = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        cc = c + dc;
        if (cc >= 0 && cc < 16) begin
          n += int'(up[cc]) + int'(down[cc]);
          if (dc != 0) n += int'(mid[cc]);
        end
      end
      res[c] = mid[c] ? (n == 2 || n == 3) : (n == 3);
    end
    return res;
  endfunction

  task automatic life_advance();
    logic [15:0] nxt [16];
    for (int r = 0; r < 16; r++)
      nxt[r] = life_row(r > 0 ? life_board[r-1] : 16'h0, life_board[r],
                        r < 15 ? life_board[r+1] : 16'h0);
    for (int r = 0; r < 16; r++) life_board[r] = nxt[r];
    gen_count_q = gen_count_q + 16'd1;
  endtask

  task automatic queue_board_rows();
    row_word_t w;
    for (int r = 0; r < 16; r++) begin
      w.row   = 4'(r);
      w.cells = life_board[r];
      w.gen   = gen_count_q;
      w.last  = (r == 15);
      rows_due.push_back(w);
    end
  endtask

  task automatic report(input string field, input logic [15:0] exp_v, input logic [15:0] act_v);
    fail_cnt++;
    $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
  endtask

  // driver: a word stays on the ports until it is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !word_taken)) begin
      if (start) void'(cmd_q.pop_front());
      if (cmd_q.size() > 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
        start     <= 1'b1;
        mode      <= cmd_q[0].mode;
        row_index <= cmd_q[0].row_index;
        row_cells <= cmd_q[0].row_cells;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each taken word, then check any emitted row
  always @(posedge clk) begin
    row_word_t w;
    if (rst) begin
      word_taken  <= 1'b0;
      gen_count_q = '0;
      for (int r = 0; r < 16; r++) life_board[r] = '0;
    end else begin
      word_taken <= start && !busy;
      if (start && !busy) begin
        case (mode)
          MODE_WRITE: life_board[row_index] = row_cells;
          MODE_STEP: begin
            life_advance();
            queue_board_rows();
          end
          MODE_EMIT: queue_board_rows();
          default: ;
        endcase
      end
      if (strobe) begin
        if (rows_due.size() == 0) begin
          fail_cnt++;
          $error("unexpected row word: out_row %0h out_cells %0h", out_row, out_cells);
        end else begin
          w = rows_due.pop_front();
          if (out_row !== w.row) report("out_row", 16'(w.row), 16'(out_row));
          if (out_cells !== w.cells) report("out_cells", w.cells, out_cells);
          if (generation !== w.gen) report("generation", w.gen, generation);
          if (last_row !== w.last) report("last_row", 16'(w.last), 16'(last_row));
        end
      end
    end
  end

  task automatic push_cmd(input logic [1:0] m, input logic [3:0] idx, input logic [15:0] cells,
                          input int idle);
    command_t c;
    c.mode      = m;
    c.row_index = idx;
    c.row_cells = cells;
    c.idle_pct  = idle;
    cmd_q.push_back(c);
  endtask

  function automatic logic [15:0] random_row();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom & $urandom);
      2: return 16'($urandom & $urandom & $urandom);
      default: return 16'(16'h7 << $urandom_range(13));
    endcase
  endfunction

  task automatic random_phase(input int count, input int idle);
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // fresh sparse board so the following steps have something to evolve
        for (int r = 0; r < 16; r++) push_cmd(MODE_WRITE, 4'(r), random_row(), idle);
        done += 16;
      end else if (pick < 50) begin
        push_cmd(MODE_WRITE, 4'($urandom), random_row(), idle);
        done++;
      end else if (pick < 80) begin
        push_cmd(MODE_STEP, 4'($urandom), 16'($urandom), idle);
        done++;
      end else if (pick < 95) begin
        push_cmd(MODE_EMIT, 4'($urandom), 16'($urandom), idle);
        done++;
      end else begin
        push_cmd(MODE_UNUSED, 4'($urandom), 16'($urandom), idle);
      end
    end
  endtask

  initial begin
    // directed: empty board, full edge rows, corner columns, ignored mode
    push_cmd(MODE_EMIT,   4'h0, 16'h0000, 0);
    push_cmd(MODE_WRITE,  4'h0, 16'hFFFF, 0);
    push_cmd(MODE_WRITE,  4'hF, 16'hFFFF, 0);
    push_cmd(MODE_WRITE,  4'h7, 16'h8001, 0);
    push_cmd(MODE_WRITE,  4'h8, 16'hC003, 0);
    push_cmd(MODE_UNUSED, 4'hF, 16'hFFFF, 0);
    push_cmd(MODE_EMIT,   4'hA, 16'h5A5A, 0);
    push_cmd(MODE_STEP,   4'h5, 16'hA5A5, 0);
    push_cmd(MODE_STEP,   4'h0, 16'h0000, 0);
    push_cmd(MODE_WRITE,  4'hF, 16'h0000, 0);
    push_cmd(MODE_WRITE,  4'h3, 16'h0007, 0);
    push_cmd(MODE_STEP,   4'hF, 16'hFFFF, 0);
    push_cmd(MODE_STEP,   4'h0, 16'h0000, 0);

    random_phase(90, 0);
    random_phase(90, 68);
    random_phase(90, 0);
    random_phase(90, 27);

    push_cmd(MODE_EMIT, 4'h0, 16'h0000, 0);

    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && rows_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/lge_pkg.sv
rtl/lge_ram.sv
rtl/life_generation_engine_top.sv
tb/tb_life_generation_engine_top.sv
